// ===== rtl/core/sbcd_pkg.sv =====
// ----------------------------------------------------------------------------
// sbcd_pkg
// Types, command codes and constants shared by the servo bus command decoder.
// ----------------------------------------------------------------------------
package sbcd_pkg;

    // Default number of servos on the bus
    localparam int SERVO_COUNT_DEF = 19;

    localparam int ADDR_W  = 10;
    localparam int POS_W   = 10;
    localparam int FLAG_W  = 2;
    localparam int CMD_W   = 4;
    localparam int REPLY_W = 16;
    localparam int SEL_W   = 5;

    // Address and position constants
    localparam logic [ADDR_W-1:0] CHAIN_OFF  = 10'd1023;
    localparam logic [ADDR_W-1:0] BROADCAST  = 10'd256;
    localparam logic [POS_W-1:0]  POS_RESET  = 10'd336;
    localparam logic [POS_W-1:0]  POS_FULL   = 10'd255;

    // Reply words of the query commands
    localparam logic [REPLY_W-1:0] REPLY_NONE = 16'h0000;
    localparam logic [REPLY_W-1:0] REPLY_A    = 16'h8008;
    localparam logic [REPLY_W-1:0] REPLY_B    = 16'h8009;
    localparam logic [REPLY_W-1:0] REPLY_C    = 16'h800D;

    // Flag bits
    localparam logic [FLAG_W-1:0] FLAG_NONE    = 2'b00;
    localparam logic [FLAG_W-1:0] FLAG_ONESHOT = 2'b01;
    localparam logic [FLAG_W-1:0] FLAG_PERSIST = 2'b10;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LISTEN     = 4'd0;
    localparam logic [CMD_W-1:0] CMD_IGNORE     = 4'd1;
    localparam logic [CMD_W-1:0] CMD_ONESHOT    = 4'd2;
    localparam logic [CMD_W-1:0] CMD_SET_FLAGS  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_SET_POS    = 4'd4;
    localparam logic [CMD_W-1:0] CMD_SET_CACHED = 4'd5;
    localparam logic [CMD_W-1:0] CMD_QUERY_A    = 4'd6;
    localparam logic [CMD_W-1:0] CMD_QUERY_B    = 4'd7;
    localparam logic [CMD_W-1:0] CMD_QUERY_C    = 4'd8;

    // Request types
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              req_type;
        logic [7:0]        rx_byte;
        logic [SEL_W-1:0]  servo_select;
    } t_req;

    typedef struct packed {
        logic [REPLY_W-1:0] reply_word;
        logic [POS_W-1:0]   commanded_position;
        logic [POS_W-1:0]   cached_position;
        logic [FLAG_W-1:0]  listen_bits;
    } t_rsp;

    typedef logic [ADDR_W-1:0] t_cfg;

    // Per-command control held for the whole sweep
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] arg;
        logic [ADDR_W-1:0] tgt;
        logic              tgt_en;
        logic              bcast;
    } t_sweep_ctrl;

endpackage

// ===== rtl/core/sbcd_chan_if.sv =====
// ----------------------------------------------------------------------------
// sbcd_chan_if
// Valid/ready channel carrying one word of a configurable payload type.
// ----------------------------------------------------------------------------
interface sbcd_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/servo_bus_command_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// servo_bus_command_decoder_unit
// Byte-level command decoder for a daisy-chained servo bus, holding the
// listen flags and positions of every servo.
// ----------------------------------------------------------------------------
// Usage:
//   i_req  takes one word per request: a received serial byte or a read of
//          one servo's state. i_cfg writes id_offset, the bus address of
//          servo zero; write it only while the block is idle.
//   o_rsp  gives exactly one result word for each request.
// Timing:
//   A read or a byte that does not complete a known command gives its
//   result word in the cycle after accept. A byte that executes a
//   command runs the shared entry unit once per servo, one entry per
//   cycle, and raises o_rsp.valid after the last entry.
//   One request is in flight at a time; i_req.ready is low from accept
//   until the result word has been taken, so a new request is taken
//   only once the result word of the last one has gone.
// Reset:
//   Synchronous, active low. Parser idle, chain inactive, all flags clear,
//   commanded positions 336, cached positions 0, id_offset 0.
// Stall:
//   While o_rsp.ready is low the result word holds and no request is taken.
// ----------------------------------------------------------------------------
module servo_bus_command_decoder_unit #(
    parameter int SERVO_COUNT = sbcd_pkg::SERVO_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sbcd_chan_if.sink          i_req,
    sbcd_chan_if.sink          i_cfg,
    sbcd_chan_if.source        o_rsp
);

    localparam int IDX_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
    localparam int SXW   = IDX_W + sbcd_pkg::SEL_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SERVO_COUNT - 1);

    sbcd_pkg::t_state r_state;
    sbcd_pkg::t_state n_state;

    // Servo table
    logic [sbcd_pkg::FLAG_W-1:0] r_flags     [SERVO_COUNT];
    logic [sbcd_pkg::POS_W-1:0]  r_cmd_pos   [SERVO_COUNT];
    logic [sbcd_pkg::POS_W-1:0]  r_cache_pos [SERVO_COUNT];

    // Parser and sequencer state
    logic                          r_second;
    logic [sbcd_pkg::CMD_W-1:0]    r_held_cmd;
    logic [sbcd_pkg::ADDR_W-1:0]   r_held_arg;
    logic [sbcd_pkg::ADDR_W-1:0]   r_chain;
    logic [sbcd_pkg::ADDR_W-1:0]   r_id_offset;
    logic [IDX_W-1:0]              r_idx;
    logic                          r_hit;
    sbcd_pkg::t_sweep_ctrl         r_ctrl;
    sbcd_pkg::t_rsp                r_rsp;

    logic                          req_acc;
    logic                          rsp_acc;
    logic                          sweep_we;
    logic                          sweep_last;
    logic                          is_byte;
    logic                          executes;
    logic [sbcd_pkg::ADDR_W-1:0]   arg_new;
    logic [sbcd_pkg::ADDR_W-1:0]   chain_next;
    logic [SXW-1:0]                sel_ext;
    logic                          sel_ok;
    logic [IDX_W-1:0]              rd_idx;
    sbcd_pkg::t_sweep_ctrl         ctrl_new;
    logic [sbcd_pkg::ADDR_W-1:0]   chain_new;
    logic [sbcd_pkg::REPLY_W-1:0]  reply_code;
    sbcd_pkg::t_rsp                rd_rsp;

    logic [sbcd_pkg::FLAG_W-1:0]   upd_flags;
    logic [sbcd_pkg::POS_W-1:0]    upd_cmd_pos;
    logic [sbcd_pkg::POS_W-1:0]    upd_cache_pos;
    logic                          upd_hit;

    assign req_acc = i_req.valid && i_req.ready;
    assign rsp_acc = o_rsp.valid && o_rsp.ready;

    // Request decode
    assign is_byte  = (i_req.data.req_type == sbcd_pkg::REQ_BYTE);
    assign arg_new  = {i_req.data.rx_byte[6:0], r_held_arg[2:0]};
    assign executes = is_byte && r_second && i_req.data.rx_byte[7]
                      && (r_held_cmd <= sbcd_pkg::CMD_QUERY_C);
    assign chain_next = r_chain + sbcd_pkg::ADDR_W'(1);

    // Single read address: request select when idle, sweep index otherwise
    assign sel_ext = SXW'(i_req.data.servo_select);
    assign sel_ok  = (sel_ext < SXW'(SERVO_COUNT));
    always_comb begin
        if (r_state == sbcd_pkg::ST_IDLE) begin
            rd_idx = sel_ok ? sel_ext[IDX_W-1:0] : '0;
        end else begin
            rd_idx = r_idx;
        end
    end

    // Result word of a request: servo state on a valid read, else zero
    always_comb begin
        rd_rsp = '0;
        if (!is_byte && sel_ok) begin
            rd_rsp.commanded_position = r_cmd_pos[rd_idx];
            rd_rsp.cached_position    = r_cache_pos[rd_idx];
            rd_rsp.listen_bits        = r_flags[rd_idx];
        end
    end

    // Sweep control and new chain address for the command being started
    always_comb begin
        ctrl_new.cmd    = r_held_cmd;
        ctrl_new.arg    = arg_new;
        ctrl_new.tgt    = arg_new;
        ctrl_new.tgt_en = 1'b1;
        ctrl_new.bcast  = 1'b0;
        chain_new       = r_chain;
        unique case (r_held_cmd)
            sbcd_pkg::CMD_LISTEN, sbcd_pkg::CMD_IGNORE: begin
                ctrl_new.bcast = (arg_new == sbcd_pkg::BROADCAST);
                chain_new      = sbcd_pkg::CHAIN_OFF;
            end
            sbcd_pkg::CMD_ONESHOT: begin
                ctrl_new.bcast = (arg_new == sbcd_pkg::BROADCAST);
                chain_new      = sbcd_pkg::CHAIN_OFF;
                if (!ctrl_new.bcast && arg_new[9]) begin
                    ctrl_new.tgt = {1'b0, arg_new[8:0]};
                    chain_new    = {1'b0, arg_new[8:0]};
                end
            end
            sbcd_pkg::CMD_SET_FLAGS, sbcd_pkg::CMD_SET_POS, sbcd_pkg::CMD_SET_CACHED: begin
                ctrl_new.tgt    = chain_next;
                ctrl_new.tgt_en = (r_chain != sbcd_pkg::CHAIN_OFF)
                                  && (chain_next != sbcd_pkg::CHAIN_OFF);
                if (r_chain != sbcd_pkg::CHAIN_OFF) chain_new = chain_next;
            end
            default: begin
            end
        endcase
    end

    // Reply word of the running command
    always_comb begin
        case (r_ctrl.cmd)
            sbcd_pkg::CMD_QUERY_A: reply_code = sbcd_pkg::REPLY_A;
            sbcd_pkg::CMD_QUERY_B: reply_code = sbcd_pkg::REPLY_B;
            sbcd_pkg::CMD_QUERY_C: reply_code = sbcd_pkg::REPLY_C;
            default:               reply_code = sbcd_pkg::REPLY_NONE;
        endcase
    end

    // Shared entry unit
    sbcd_sweep_unit #(
        .IDX_W (IDX_W)
    ) u_sweep (
        .i_ctrl      (r_ctrl),
        .i_idx       (r_idx),
        .i_id_offset (r_id_offset),
        .i_flags     (r_flags[rd_idx]),
        .i_cmd_pos   (r_cmd_pos[rd_idx]),
        .i_cache_pos (r_cache_pos[rd_idx]),
        .o_flags     (upd_flags),
        .o_cmd_pos   (upd_cmd_pos),
        .o_cache_pos (upd_cache_pos),
        .o_hit       (upd_hit)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sbcd_pkg::ST_IDLE: begin
                if (req_acc) n_state = executes ? sbcd_pkg::ST_SWEEP : sbcd_pkg::ST_OUT;
            end
            sbcd_pkg::ST_SWEEP: begin
                if (sweep_last) n_state = sbcd_pkg::ST_OUT;
            end
            sbcd_pkg::ST_OUT: begin
                if (rsp_acc) n_state = sbcd_pkg::ST_IDLE;
            end
            default: n_state = sbcd_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        i_req.ready = 1'b0;
        o_rsp.valid = 1'b0;
        sweep_we    = 1'b0;
        unique case (r_state)
            sbcd_pkg::ST_IDLE:  i_req.ready = 1'b1;
            sbcd_pkg::ST_SWEEP: sweep_we    = 1'b1;
            sbcd_pkg::ST_OUT:   o_rsp.valid = 1'b1;
            default: begin
            end
        endcase
    end

    assign sweep_last  = sweep_we && (r_idx == LAST_IDX);
    assign o_rsp.data  = r_rsp;
    assign i_cfg.ready = 1'b1;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbcd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_offset <= '0;
        end else if (i_cfg.valid) begin
            r_id_offset <= i_cfg.data;
        end
    end

    // Parser, chain and sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second   <= 1'b0;
            r_held_cmd <= '0;
            r_held_arg <= '0;
            r_chain    <= sbcd_pkg::CHAIN_OFF;
            r_idx      <= '0;
            r_hit      <= 1'b0;
        end else begin
            if (req_acc && is_byte) begin
                if (!r_second) begin
                    if (!i_req.data.rx_byte[7]) begin
                        r_second   <= 1'b1;
                        r_held_cmd <= i_req.data.rx_byte[6:3];
                        r_held_arg <= {r_held_arg[9:3], i_req.data.rx_byte[2:0]};
                    end
                end else begin
                    r_second <= 1'b0;
                    if (i_req.data.rx_byte[7]) r_held_arg <= arg_new;
                end
            end
            if (req_acc && executes) begin
                r_chain <= chain_new;
                r_hit   <= 1'b0;
            end
            if (sweep_we) begin
                r_idx <= sweep_last ? '0 : r_idx + IDX_W'(1);
                r_hit <= r_hit | upd_hit;
            end
        end
    end

    // Held sweep control and result word
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_ctrl <= ctrl_new;
            r_rsp  <= rd_rsp;
        end else if (sweep_last) begin
            r_rsp.reply_word <= (r_hit || upd_hit) ? reply_code : sbcd_pkg::REPLY_NONE;
        end
    end

    // Servo table write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SERVO_COUNT; i++) begin
                r_flags[i]     <= sbcd_pkg::FLAG_NONE;
                r_cmd_pos[i]   <= sbcd_pkg::POS_RESET;
                r_cache_pos[i] <= '0;
            end
        end else if (sweep_we) begin
            r_flags[r_idx]     <= upd_flags;
            r_cmd_pos[r_idx]   <= upd_cmd_pos;
            r_cache_pos[r_idx] <= upd_cache_pos;
        end
    end

    // Assertions
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !i_req.ready)
        else $error("request taken while a result word is pending");

    a_idx_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != sbcd_pkg::ST_SWEEP) |-> (r_idx == '0))
        else $error("sweep index not home outside a sweep");

    a_sweep_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sweep_last |=> o_rsp.valid)
        else $error("no result word after the last entry");

    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !req_acc |=> $stable(r_chain))
        else $error("chain address moved without a request");

endmodule

// ===== rtl/core/sbcd_sweep_unit.sv =====
// ----------------------------------------------------------------------------
// sbcd_sweep_unit
// Shared per-entry unit: address match for one servo and the update of its
// flags and positions for the command being executed.
// ----------------------------------------------------------------------------
module sbcd_sweep_unit #(
    parameter int IDX_W = 5
) (
    input  sbcd_pkg::t_sweep_ctrl          i_ctrl,
    input  logic [IDX_W-1:0]               i_idx,
    input  logic [sbcd_pkg::ADDR_W-1:0]    i_id_offset,
    input  logic [sbcd_pkg::FLAG_W-1:0]    i_flags,
    input  logic [sbcd_pkg::POS_W-1:0]     i_cmd_pos,
    input  logic [sbcd_pkg::POS_W-1:0]     i_cache_pos,
    output logic [sbcd_pkg::FLAG_W-1:0]    o_flags,
    output logic [sbcd_pkg::POS_W-1:0]     o_cmd_pos,
    output logic [sbcd_pkg::POS_W-1:0]     o_cache_pos,
    output logic                           o_hit
);

    logic [sbcd_pkg::ADDR_W:0] addr;
    logic                      match;
    logic                      listening;

    // Bus address of this entry; one bit wider so addresses past 1023 never match
    assign addr      = {1'b0, i_id_offset} + (sbcd_pkg::ADDR_W + 1)'(i_idx);
    assign match     = i_ctrl.tgt_en && (addr == {1'b0, i_ctrl.tgt});
    assign listening = (i_flags != sbcd_pkg::FLAG_NONE);

    // Entry update
    always_comb begin
        o_flags     = i_flags;
        o_cmd_pos   = i_cmd_pos;
        o_cache_pos = i_cache_pos;
        o_hit       = 1'b0;
        unique case (i_ctrl.cmd)
            sbcd_pkg::CMD_LISTEN: begin
                if (i_ctrl.bcast || match) o_flags = i_flags | sbcd_pkg::FLAG_PERSIST;
            end
            sbcd_pkg::CMD_IGNORE: begin
                if (i_ctrl.bcast || match) o_flags = sbcd_pkg::FLAG_NONE;
            end
            sbcd_pkg::CMD_ONESHOT: begin
                if (i_ctrl.bcast || match) o_flags = i_flags | sbcd_pkg::FLAG_ONESHOT;
            end
            sbcd_pkg::CMD_SET_FLAGS, sbcd_pkg::CMD_SET_POS, sbcd_pkg::CMD_SET_CACHED: begin
                if (i_ctrl.cmd == sbcd_pkg::CMD_SET_FLAGS) begin
                    if (i_ctrl.arg[0]) o_cmd_pos = i_cache_pos;
                    if (i_ctrl.arg[3] && listening) o_cmd_pos = sbcd_pkg::POS_FULL;
                end else if (i_ctrl.cmd == sbcd_pkg::CMD_SET_POS) begin
                    if (listening) o_cmd_pos = i_ctrl.arg;
                end else begin
                    if (listening) o_cache_pos = i_ctrl.arg;
                end
                // one-shot flags expire; the new chain servo listens once
                o_flags = i_flags & sbcd_pkg::FLAG_PERSIST;
                if (match) o_flags = sbcd_pkg::FLAG_ONESHOT;
            end
            sbcd_pkg::CMD_QUERY_A, sbcd_pkg::CMD_QUERY_B, sbcd_pkg::CMD_QUERY_C: begin
                o_hit = match;
            end
            default: begin
            end
        endcase
    end

endmodule
